/* hdl/ikf_pkg.sv */
// Shared types, codes and constants of the IMU angle Kalman filter.
package ikf_pkg;

  localparam int NUM_AXES_DEF = 3;
  localparam int DIV_W = 57;
  localparam int CNT_W = $clog2(DIV_W);

  localparam logic [30:0] Q_ANGLE_RST = 31'd16777;
  localparam logic [30:0] Q_BIAS_RST = 31'd50332;
  localparam logic [30:0] R_MEAS_RST = 31'd503316;
  localparam logic signed [31:0] ONE_Q24 = 32'sd16777216;

  localparam logic [1:0] REG_Q_ANGLE = 2'd0;
  localparam logic [1:0] REG_Q_BIAS = 2'd1;
  localparam logic [1:0] REG_R_MEAS = 2'd2;

  localparam logic [1:0] STAT_FULL = 2'd0;
  localparam logic [1:0] STAT_READ = 2'd1;
  localparam logic [1:0] STAT_PRED = 2'd2;

  localparam logic [4:0] OP_NONE = 5'd0;
  localparam logic [4:0] OP_LOAD = 5'd1;
  localparam logic [4:0] OP_M_ANG = 5'd2;
  localparam logic [4:0] OP_A_ANG = 5'd3;
  localparam logic [4:0] OP_M_DTP = 5'd4;
  localparam logic [4:0] OP_A_DTP = 5'd5;
  localparam logic [4:0] OP_M_P00 = 5'd6;
  localparam logic [4:0] OP_A_P00 = 5'd7;
  localparam logic [4:0] OP_M_P11 = 5'd8;
  localparam logic [4:0] OP_A_P11 = 5'd9;
  localparam logic [4:0] OP_DIV_START = 5'd10;
  localparam logic [4:0] OP_DIV_STEP = 5'd11;
  localparam logic [4:0] OP_DIV_END = 5'd12;
  localparam logic [4:0] OP_M_K0Y = 5'd13;
  localparam logic [4:0] OP_A_K0Y = 5'd14;
  localparam logic [4:0] OP_M_K1Y = 5'd15;
  localparam logic [4:0] OP_A_K1Y = 5'd16;
  localparam logic [4:0] OP_M_K1P = 5'd17;
  localparam logic [4:0] OP_A_K1P = 5'd18;
  localparam logic [4:0] OP_M_K0P = 5'd19;
  localparam logic [4:0] OP_A_K0P = 5'd20;
  localparam logic [4:0] OP_M_K0Q = 5'd21;
  localparam logic [4:0] OP_A_K0Q = 5'd22;
  localparam logic [4:0] OP_STORE = 5'd23;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] status;
    logic       wr_state;
  } ikf_cmd_t;

  typedef struct packed {
    logic dt_zero;
    logic axis_bad;
    logic s_zero;
  } ikf_stat_t;

endpackage

/* hdl/ikf_in_if.sv */
// Input item channel of the IMU angle Kalman filter.
interface ikf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         axis;
  logic signed [31:0] accel_angle;
  logic signed [31:0] measured_rate;
  logic [15:0]        time_step;

  modport source (output valid, axis, accel_angle, measured_rate, time_step, input ready);
  modport sink (input valid, axis, accel_angle, measured_rate, time_step, output ready);
endinterface

/* hdl/ikf_out_if.sv */
// Result item channel of the IMU angle Kalman filter.
interface ikf_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         axis_out;
  logic signed [31:0] angle_estimate;
  logic signed [31:0] bias_estimate;
  logic [1:0]         status;

  modport source (output valid, axis_out, angle_estimate, bias_estimate, status, input ready);
  modport sink (input valid, axis_out, angle_estimate, bias_estimate, status, output ready);
endinterface

/* hdl/ikf_cfg_if.sv */
// Configuration write channel of the IMU angle Kalman filter.
interface ikf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/imu_angle_kalman_filter.sv */
// Top level of the three-axis angle and gyro bias Kalman filter.
// A full update runs the 57-step radix-2 gain divider, which serves both gains in two lanes.
// A zero time step or an unknown axis gives its result without the filter steps.
// One item is in work at a time; the next is accepted in the cycle after the result loads.
// Synchronous active-low reset sets zero angle and bias, unit variances and default noises.
module imu_angle_kalman_filter #(
  parameter int NUM_AXES = ikf_pkg::NUM_AXES_DEF
) (
  input logic clk,
  input logic rst_n,
  ikf_in_if.sink    in_ch,
  ikf_out_if.source out_ch,
  ikf_cfg_if.sink   cfg_ch
);

  ikf_pkg::ikf_cmd_t  cmd;
  ikf_pkg::ikf_stat_t stat;
  logic               in_ready;

  assign in_ch.ready = in_ready;
  assign cfg_ch.ready = 1'b1;

  ikf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ikf_datapath #(.NUM_AXES(NUM_AXES)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_ch.valid && in_ready),
    .in_axis    (in_ch.axis),
    .in_angle   (in_ch.accel_angle),
    .in_rate    (in_ch.measured_rate),
    .in_dt      (in_ch.time_step),
    .cfg_we     (cfg_ch.valid),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .cmd        (cmd),
    .stat       (stat),
    .out_axis   (out_ch.axis_out),
    .out_angle  (out_ch.angle_estimate),
    .out_bias   (out_ch.bias_estimate),
    .out_status (out_ch.status)
  );

endmodule

/* hdl/ikf_datapath.sv */
// Datapath: per-axis state, shared multiplier, two-lane divider and result register.
module ikf_datapath #(
  parameter int NUM_AXES = ikf_pkg::NUM_AXES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_accept,
  input  logic [1:0]         in_axis,
  input  logic signed [31:0] in_angle,
  input  logic signed [31:0] in_rate,
  input  logic [15:0]        in_dt,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  ikf_pkg::ikf_cmd_t  cmd,
  output ikf_pkg::ikf_stat_t stat,
  output logic [1:0]         out_axis,
  output logic signed [31:0] out_angle,
  output logic signed [31:0] out_bias,
  output logic [1:0]         out_status
);

  localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int DIV_Q = ikf_pkg::DIV_W - 1;

  function automatic logic signed [68:0] rnd16(input logic signed [67:0] p);
    rnd16 = ($signed({p[67], p}) + 69'sd32768) >>> 16;
  endfunction

  function automatic logic signed [68:0] rnd24(input logic signed [67:0] p);
    rnd24 = ($signed({p[67], p}) + 69'sd8388608) >>> 24;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
    if (v > 70'sd2147483647) sat32 = 32'sh7FFFFFFF;
    else if (v < -70'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  function automatic logic signed [31:0] gain(input logic [DIV_Q:0] q, input logic neg);
    if (!neg) gain = (q > 57'd2147483647) ? 32'sh7FFFFFFF : q[31:0];
    else gain = (q >= 57'd2147483648) ? 32'sh80000000 : -q[31:0];
  endfunction

  logic [30:0] q_angle_r, q_bias_r, r_meas_r;

  logic signed [31:0] ang_mem [NUM_AXES];
  logic signed [31:0] bia_mem [NUM_AXES];
  logic signed [31:0] p00_mem [NUM_AXES];
  logic signed [31:0] p01_mem [NUM_AXES];
  logic signed [31:0] p11_mem [NUM_AXES];

  logic [1:0]         axis_r;
  logic signed [31:0] meas_r, rate_r;
  logic [15:0]        dt_r;
  logic signed [31:0] ang_r, bia_r, p00_r, p01_r, p11_r;
  logic signed [33:0] dtp_r;
  logic signed [67:0] prod_r;
  logic signed [31:0] k0_r, k1_r, y_r;
  logic [DIV_Q:0]     q0_r, q1_r;
  logic [32:0]        rem0_r, rem1_r;
  logic [32:0]        ad_r;
  logic               neg0_r, neg1_r;

  logic [1:0]         oaxis_r, ostat_r;
  logic signed [31:0] oang_r, obia_r;

  logic               axis_ok;
  logic [AW-1:0]      idx;
  logic signed [34:0] a_op;
  logic signed [32:0] b_op;
  logic signed [35:0] inner;
  logic signed [32:0] s_val;
  logic signed [32:0] dt_s;
  logic [33:0]        t0, t1;
  logic [32:0]        an0, an1;
  logic [32:0]        abs_s;
  logic signed [68:0] prod_r16;

  assign axis_ok = ({30'd0, axis_r} < NUM_AXES);
  assign idx = AW'(axis_r);
  assign dt_s = {17'd0, dt_r};
  assign s_val = {p00_r[31], p00_r} + {2'b00, r_meas_r};
  assign inner = {{2{dtp_r[33]}}, dtp_r} - {{3{p01_r[31]}}, p01_r, 1'b0}
                 + {5'd0, q_angle_r};
  assign abs_s = s_val[32] ? 33'(-s_val) : 33'(s_val);
  assign an0 = p00_r[31] ? 33'(-{p00_r[31], p00_r}) : {1'b0, p00_r};
  assign an1 = p01_r[31] ? 33'(-{p01_r[31], p01_r}) : {1'b0, p01_r};
  assign t0 = {rem0_r, q0_r[DIV_Q]};
  assign t1 = {rem1_r, q1_r[DIV_Q]};
  assign prod_r16 = rnd16(prod_r);

  assign stat.dt_zero = (dt_r == 16'd0);
  assign stat.axis_bad = !axis_ok;
  assign stat.s_zero = (s_val == 33'sd0);

  always_comb begin
    a_op = '0;
    b_op = '0;
    unique case (cmd.op)
      ikf_pkg::OP_M_ANG: begin
        a_op = 35'(rate_r) - 35'(bia_r);
        b_op = dt_s;
      end
      ikf_pkg::OP_M_DTP: begin
        a_op = 35'(p11_r);
        b_op = dt_s;
      end
      ikf_pkg::OP_M_P00: begin
        a_op = inner[34:0];
        b_op = dt_s;
      end
      ikf_pkg::OP_M_P11: begin
        a_op = {4'd0, q_bias_r};
        b_op = dt_s;
      end
      ikf_pkg::OP_M_K0Y: begin
        a_op = 35'(k0_r);
        b_op = 33'(y_r);
      end
      ikf_pkg::OP_M_K1Y: begin
        a_op = 35'(k1_r);
        b_op = 33'(y_r);
      end
      ikf_pkg::OP_M_K1P: begin
        a_op = 35'(k1_r);
        b_op = 33'(p01_r);
      end
      ikf_pkg::OP_M_K0P: begin
        a_op = 35'(k0_r);
        b_op = 33'(p01_r);
      end
      ikf_pkg::OP_M_K0Q: begin
        a_op = 35'(k0_r);
        b_op = 33'(p00_r);
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_angle_r <= ikf_pkg::Q_ANGLE_RST;
      q_bias_r <= ikf_pkg::Q_BIAS_RST;
      r_meas_r <= ikf_pkg::R_MEAS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ikf_pkg::REG_Q_ANGLE: q_angle_r <= cfg_data[30:0];
        ikf_pkg::REG_Q_BIAS: q_bias_r <= cfg_data[30:0];
        ikf_pkg::REG_R_MEAS: r_meas_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        ang_mem[i] <= '0;
        bia_mem[i] <= '0;
        p00_mem[i] <= ikf_pkg::ONE_Q24;
        p01_mem[i] <= '0;
        p11_mem[i] <= ikf_pkg::ONE_Q24;
      end
    end else if (cmd.op == ikf_pkg::OP_STORE && cmd.wr_state && axis_ok) begin
      ang_mem[idx] <= ang_r;
      bia_mem[idx] <= bia_r;
      p00_mem[idx] <= p00_r;
      p01_mem[idx] <= p01_r;
      p11_mem[idx] <= p11_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      axis_r <= in_axis;
      meas_r <= in_angle;
      rate_r <= in_rate;
      dt_r <= in_dt;
    end
    unique case (cmd.op)
      ikf_pkg::OP_LOAD: begin
        if (axis_ok) begin
          ang_r <= ang_mem[idx];
          bia_r <= bia_mem[idx];
          p00_r <= p00_mem[idx];
          p01_r <= p01_mem[idx];
          p11_r <= p11_mem[idx];
        end else begin
          ang_r <= '0;
          bia_r <= '0;
          p00_r <= '0;
          p01_r <= '0;
          p11_r <= '0;
        end
      end
      ikf_pkg::OP_M_ANG, ikf_pkg::OP_M_DTP, ikf_pkg::OP_M_P00, ikf_pkg::OP_M_P11,
      ikf_pkg::OP_M_K0Y, ikf_pkg::OP_M_K1Y, ikf_pkg::OP_M_K1P, ikf_pkg::OP_M_K0P,
      ikf_pkg::OP_M_K0Q: begin
        prod_r <= a_op * b_op;
      end
      ikf_pkg::OP_A_ANG: ang_r <= sat32(70'(ang_r) + 70'(rnd16(prod_r)));
      ikf_pkg::OP_A_DTP: dtp_r <= prod_r16[33:0];
      ikf_pkg::OP_A_P00: begin
        p00_r <= sat32(70'(p00_r) + 70'(rnd16(prod_r)));
        p01_r <= sat32(70'(p01_r) - 70'(dtp_r));
      end
      ikf_pkg::OP_A_P11: p11_r <= sat32(70'(p11_r) + 70'(rnd16(prod_r)));
      ikf_pkg::OP_DIV_START: begin
        // Dividend already carries the half-divisor so the quotient rounds.
        q0_r <= {an0, 24'd0} + {25'd0, abs_s[32:1]};
        q1_r <= {an1, 24'd0} + {25'd0, abs_s[32:1]};
        rem0_r <= '0;
        rem1_r <= '0;
        ad_r <= abs_s;
        neg0_r <= p00_r[31] ^ s_val[32];
        neg1_r <= p01_r[31] ^ s_val[32];
      end
      ikf_pkg::OP_DIV_STEP: begin
        if (t0 >= {1'b0, ad_r}) begin
          rem0_r <= 33'(t0 - {1'b0, ad_r});
          q0_r <= {q0_r[DIV_Q-1:0], 1'b1};
        end else begin
          rem0_r <= t0[32:0];
          q0_r <= {q0_r[DIV_Q-1:0], 1'b0};
        end
        if (t1 >= {1'b0, ad_r}) begin
          rem1_r <= 33'(t1 - {1'b0, ad_r});
          q1_r <= {q1_r[DIV_Q-1:0], 1'b1};
        end else begin
          rem1_r <= t1[32:0];
          q1_r <= {q1_r[DIV_Q-1:0], 1'b0};
        end
      end
      ikf_pkg::OP_DIV_END: begin
        k0_r <= gain(q0_r, neg0_r);
        k1_r <= gain(q1_r, neg1_r);
        y_r <= sat32(70'(meas_r) - 70'(ang_r));
      end
      ikf_pkg::OP_A_K0Y: ang_r <= sat32(70'(ang_r) + 70'(rnd24(prod_r)));
      ikf_pkg::OP_A_K1Y: bia_r <= sat32(70'(bia_r) + 70'(rnd24(prod_r)));
      ikf_pkg::OP_A_K1P: p11_r <= sat32(70'(p11_r) - 70'(rnd24(prod_r)));
      ikf_pkg::OP_A_K0P: p01_r <= sat32(70'(p01_r) - 70'(rnd24(prod_r)));
      ikf_pkg::OP_A_K0Q: p00_r <= sat32(70'(p00_r) - 70'(rnd24(prod_r)));
      ikf_pkg::OP_STORE: begin
        oaxis_r <= axis_r;
        oang_r <= ang_r;
        obia_r <= bia_r;
        ostat_r <= cmd.status;
      end
      default: ;
    endcase
  end

  assign out_axis = oaxis_r;
  assign out_angle = oang_r;
  assign out_bias = obia_r;
  assign out_status = ostat_r;

endmodule

/* hdl/ikf_ctrl.sv */
// Controller: sequences one item through predict, divide and update steps.
module ikf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ikf_pkg::ikf_stat_t stat,
  output ikf_pkg::ikf_cmd_t  cmd
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_LOAD = 5'd1;
  localparam logic [4:0] ST_M_ANG = 5'd2;
  localparam logic [4:0] ST_A_ANG = 5'd3;
  localparam logic [4:0] ST_M_DTP = 5'd4;
  localparam logic [4:0] ST_A_DTP = 5'd5;
  localparam logic [4:0] ST_M_P00 = 5'd6;
  localparam logic [4:0] ST_A_P00 = 5'd7;
  localparam logic [4:0] ST_M_P11 = 5'd8;
  localparam logic [4:0] ST_A_P11 = 5'd9;
  localparam logic [4:0] ST_DIV_START = 5'd10;
  localparam logic [4:0] ST_DIV_STEP = 5'd11;
  localparam logic [4:0] ST_DIV_END = 5'd12;
  localparam logic [4:0] ST_M_K0Y = 5'd13;
  localparam logic [4:0] ST_A_K0Y = 5'd14;
  localparam logic [4:0] ST_M_K1Y = 5'd15;
  localparam logic [4:0] ST_A_K1Y = 5'd16;
  localparam logic [4:0] ST_M_K1P = 5'd17;
  localparam logic [4:0] ST_A_K1P = 5'd18;
  localparam logic [4:0] ST_M_K0P = 5'd19;
  localparam logic [4:0] ST_A_K0P = 5'd20;
  localparam logic [4:0] ST_M_K0Q = 5'd21;
  localparam logic [4:0] ST_A_K0Q = 5'd22;
  localparam logic [4:0] ST_OUT = 5'd23;

  localparam logic [ikf_pkg::CNT_W-1:0] CNT_LAST = ikf_pkg::CNT_W'(ikf_pkg::DIV_W - 1);

  logic [4:0]                state_r, state_nxt;
  logic [ikf_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]                status_r, status_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    status_nxt = status_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op = ikf_pkg::OP_NONE;
    cmd.status = status_r;
    cmd.wr_state = (status_r != ikf_pkg::STAT_READ);
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_LOAD;
      ST_LOAD: begin
        cmd.op = ikf_pkg::OP_LOAD;
        state_nxt = ST_M_ANG;
        status_nxt = ikf_pkg::STAT_FULL;
      end
      ST_M_ANG: begin
        // Bad axis and zero step are known only once the item is registered.
        if (stat.axis_bad || stat.dt_zero) begin
          status_nxt = ikf_pkg::STAT_READ;
          state_nxt = ST_OUT;
        end else begin
          cmd.op = ikf_pkg::OP_M_ANG;
          state_nxt = ST_A_ANG;
        end
      end
      ST_A_ANG: begin cmd.op = ikf_pkg::OP_A_ANG; state_nxt = ST_M_DTP; end
      ST_M_DTP: begin cmd.op = ikf_pkg::OP_M_DTP; state_nxt = ST_A_DTP; end
      ST_A_DTP: begin cmd.op = ikf_pkg::OP_A_DTP; state_nxt = ST_M_P00; end
      ST_M_P00: begin cmd.op = ikf_pkg::OP_M_P00; state_nxt = ST_A_P00; end
      ST_A_P00: begin cmd.op = ikf_pkg::OP_A_P00; state_nxt = ST_M_P11; end
      ST_M_P11: begin cmd.op = ikf_pkg::OP_M_P11; state_nxt = ST_A_P11; end
      ST_A_P11: begin cmd.op = ikf_pkg::OP_A_P11; state_nxt = ST_DIV_START; end
      ST_DIV_START: begin
        if (stat.s_zero) begin
          status_nxt = ikf_pkg::STAT_PRED;
          state_nxt = ST_OUT;
        end else begin
          cmd.op = ikf_pkg::OP_DIV_START;
          cnt_nxt = '0;
          state_nxt = ST_DIV_STEP;
        end
      end
      ST_DIV_STEP: begin
        cmd.op = ikf_pkg::OP_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) state_nxt = ST_DIV_END;
      end
      ST_DIV_END: begin cmd.op = ikf_pkg::OP_DIV_END; state_nxt = ST_M_K0Y; end
      ST_M_K0Y: begin cmd.op = ikf_pkg::OP_M_K0Y; state_nxt = ST_A_K0Y; end
      ST_A_K0Y: begin cmd.op = ikf_pkg::OP_A_K0Y; state_nxt = ST_M_K1Y; end
      ST_M_K1Y: begin cmd.op = ikf_pkg::OP_M_K1Y; state_nxt = ST_A_K1Y; end
      ST_A_K1Y: begin cmd.op = ikf_pkg::OP_A_K1Y; state_nxt = ST_M_K1P; end
      ST_M_K1P: begin cmd.op = ikf_pkg::OP_M_K1P; state_nxt = ST_A_K1P; end
      ST_A_K1P: begin cmd.op = ikf_pkg::OP_A_K1P; state_nxt = ST_M_K0P; end
      ST_M_K0P: begin cmd.op = ikf_pkg::OP_M_K0P; state_nxt = ST_A_K0P; end
      ST_A_K0P: begin cmd.op = ikf_pkg::OP_A_K0P; state_nxt = ST_M_K0Q; end
      ST_M_K0Q: begin cmd.op = ikf_pkg::OP_M_K0Q; state_nxt = ST_A_K0Q; end
      ST_A_K0Q: begin cmd.op = ikf_pkg::OP_A_K0Q; state_nxt = ST_OUT; end
      ST_OUT: begin
        if (out_free) begin
          cmd.op = ikf_pkg::OP_STORE;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      status_r <= ikf_pkg::STAT_FULL;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      status_r <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_LOAD)
    else $error("accepted item did not start with a state load");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV_STEP && cnt_r == CNT_LAST |=> state_r == ST_DIV_END)
    else $error("divider did not finish after its last step");

  a_store_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == ikf_pkg::OP_STORE |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while its item waits");

  a_read_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == ikf_pkg::OP_STORE && cmd.status == ikf_pkg::STAT_READ |-> !cmd.wr_state)
    else $error("read-only item would write axis state");

endmodule
